// ===== hdl/rgb_to_hsv_color_threshold_defines.svh =====
// Assertion helpers for the port-level checker in hdl/rhsv_checker.sv.
`ifndef RGB_TO_HSV_COLOR_THRESHOLD_DEFINES_SVH
`define RGB_TO_HSV_COLOR_THRESHOLD_DEFINES_SVH

// Concurrent assertion, muted while reset is held
`define RHSV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also checks during reset
`define RHSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rhsv_pkg.sv =====
package rhsv_pkg;

	// field widths
	localparam int VAL_W     = 8;
	localparam int HUE_W     = 15;
	localparam int SAT_W     = 13;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 3;

	// register reset values
	localparam logic [HUE_W-1:0] HUE_MIN_RST = 15'd0;
	localparam logic [HUE_W-1:0] HUE_MAX_RST = 15'd23039;
	localparam logic [SAT_W-1:0] SAT_MIN_RST = 13'd0;
	localparam logic [SAT_W-1:0] SAT_MAX_RST = 13'd6400;
	localparam logic [VAL_W-1:0] VAL_MIN_RST = 8'd0;
	localparam logic [VAL_W-1:0] VAL_MAX_RST = 8'd255;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HUE_MIN = 3'd0,
		CFG_HUE_MAX = 3'd1,
		CFG_SAT_MIN = 3'd2,
		CFG_SAT_MAX = 3'd3,
		CFG_VAL_MIN = 3'd4,
		CFG_VAL_MAX = 3'd5
	} cfg_reg_t;

	// which channel holds the maximum
	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// per-pixel side info carried alongside the dividers
	typedef struct packed {
		logic [VAL_W-1:0] mx;
		sector_t          sector;
		logic             neg;
		logic             gray;
	} side_t;

endpackage

// ===== hdl/rhsv_ifs.sv =====
// pixel request channel
interface rhsv_pix_if;
	import rhsv_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] red;
	logic [VAL_W-1:0] green;
	logic [VAL_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

// classification result channel
interface rhsv_res_if;
	import rhsv_pkg::*;

	logic             valid;
	logic             ready;
	logic             pass;
	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] saturation;
	logic [VAL_W-1:0] brightness;

	modport source (output valid, pass, hue, saturation, brightness, input ready);
	modport sink (input valid, pass, hue, saturation, brightness, output ready);
endinterface

// ===== hdl/rhsv_div.sv =====
// Pipelined restoring divider: STEP quotient bits per stage, 8-bit divisor.
// Quotient shifts into the low end of the numerator word as it empties.
module rhsv_div #(
	parameter int NUM_W = 21,
	parameter int STEP  = 4,
	localparam int STAGES = (NUM_W + STEP - 1) / STEP
) (
	input  logic              clk,
	input  logic [STAGES-1:0] en,
	input  logic [NUM_W-1:0]  num,
	input  logic [7:0]        den,
	output logic [NUM_W-1:0]  quo,
	output logic [7:0]        rem
);
	localparam int PW = STAGES * STEP;

	logic [PW-1:0] w_s   [STAGES];
	logic [7:0]    rem_s [STAGES];
	logic [7:0]    den_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [PW-1:0] w_in, w_nx;
		logic [7:0]    r_in, r_nx, d_in;
		logic [8:0]    t;

		if (k == 0) begin : g_first
			assign w_in = PW'(num);
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign w_in = w_s[k-1];
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
		end

		// STEP shift/compare/subtract steps
		always_comb begin
			w_nx = w_in;
			r_nx = r_in;
			t    = '0;
			for (int i = 0; i < STEP; i++) begin
				t    = {r_nx, w_nx[PW-1]};
				w_nx = {w_nx[PW-2:0], 1'b0};
				if (t >= {1'b0, d_in}) begin
					t       = t - {1'b0, d_in};
					w_nx[0] = 1'b1;
				end
				r_nx = t[7:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				w_s[k]   <= w_nx;
				rem_s[k] <= r_nx;
				den_s[k] <= d_in;
			end
		end
	end

	assign quo = w_s[STAGES-1][NUM_W-1:0];
	assign rem = rem_s[STAGES-1];

endmodule

// ===== hdl/rgb_to_hsv_color_threshold.sv =====
// RGB to HSV conversion with hue/saturation/value window test.
// pixel  : request channel carrying red, green, blue (8 bits each).
// result : pass flag, hue (1/2^FRAC_BITS deg), saturation (1/2^FRAC_BITS %),
//          brightness (largest channel). One result per pixel, in order.
// cfg    : write port; cfg_index selects hue_min, hue_max, sat_min, sat_max,
//          val_min, val_max (indexes 0..5); data is truncated to register width.
//          Write only while no pixel is in flight.
// Throughput: one pixel per clock while no receiver stall backs up the pipeline.
// Each divider has DIV_STAGES = ceil(NUM_W / 4) stages, where
// NUM_W = clog2(25500 * 2^FRAC_BITS + 1).
// The two pipelined dividers (hue and saturation) retire four quotient
// bits per stage.
// Every stage has its own valid bit and advances when the next stage is
// empty or moving, so bubbles close up and a pixel is taken while a result
// waits at the output. A receiver stall holds the result stable and backs
// the pipeline up stage by stage; nothing is dropped or repeated.
// Reset (arst_n low) empties the pipeline and loads the register defaults:
// a fully open window (hue 0..23039, sat 0..6400, value 0..255).
module rgb_to_hsv_color_threshold #(
	parameter int FRAC_BITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rhsv_pix_if.sink                      pixel,
	rhsv_res_if.source                    result,
	input  logic                          cfg_wr_en,
	input  logic [rhsv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rhsv_pkg::CFG_W-1:0]     cfg_data
);
	import rhsv_pkg::*;

	localparam int NUM_W      = $clog2(100 * 255 * (1 << FRAC_BITS) + 1);
	localparam int STEP       = 4;
	localparam int DIV_STAGES = (NUM_W + STEP - 1) / STEP;
	localparam int NS         = DIV_STAGES + 4;
	localparam int ST_FIX     = DIV_STAGES + 2;
	localparam int ST_OUT     = DIV_STAGES + 3;

	localparam logic [HUE_W-1:0] H120 = HUE_W'(120 * (1 << FRAC_BITS));
	localparam logic [HUE_W-1:0] H240 = HUE_W'(240 * (1 << FRAC_BITS));
	localparam logic [HUE_W-1:0] H360 = HUE_W'(360 * (1 << FRAC_BITS));

	// configuration registers
	logic [HUE_W-1:0] hue_min_q, hue_max_q;
	logic [SAT_W-1:0] sat_min_q, sat_max_q;
	logic [VAL_W-1:0] val_min_q, val_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_min_q <= HUE_MIN_RST;
			hue_max_q <= HUE_MAX_RST;
			sat_min_q <= SAT_MIN_RST;
			sat_max_q <= SAT_MAX_RST;
			val_min_q <= VAL_MIN_RST;
			val_max_q <= VAL_MAX_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_HUE_MIN: hue_min_q <= cfg_data[HUE_W-1:0];
				CFG_HUE_MAX: hue_max_q <= cfg_data[HUE_W-1:0];
				CFG_SAT_MIN: sat_min_q <= cfg_data[SAT_W-1:0];
				CFG_SAT_MAX: sat_max_q <= cfg_data[SAT_W-1:0];
				CFG_VAL_MIN: val_min_q <= cfg_data[VAL_W-1:0];
				CFG_VAL_MAX: val_max_q <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valid bits and per-stage ready chain
	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;
	logic [NS-1:0] vld_in;

	always_comb begin
		rdy[NS] = result.ready;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign vld_in = {vld_q[NS-2:0], pixel.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (rdy[k]) vld_q[k] <= vld_in[k];
			end
		end
	end

	assign pixel.ready = rdy[0];

	// stage 1: max/min, sector, signed channel difference
	logic             red_max, green_max;
	logic [VAL_W-1:0] mx, mn;
	logic [VAL_W:0]   diff;
	side_t            side_c;
	side_t            side_s1, side_s2;
	logic [VAL_W-1:0] ax_s1, d_s1;

	always_comb begin
		red_max   = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
		green_max = !red_max && (pixel.green >= pixel.blue);
		mn = (pixel.red < pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue < mn) mn = pixel.blue;
		if (red_max) begin
			mx            = pixel.red;
			side_c.sector = SEC_RED;
			diff          = {1'b0, pixel.green} - {1'b0, pixel.blue};
		end else if (green_max) begin
			mx            = pixel.green;
			side_c.sector = SEC_GREEN;
			diff          = {1'b0, pixel.blue} - {1'b0, pixel.red};
		end else begin
			mx            = pixel.blue;
			side_c.sector = SEC_BLUE;
			diff          = {1'b0, pixel.red} - {1'b0, pixel.green};
		end
		side_c.mx   = mx;
		side_c.neg  = diff[VAL_W];
		side_c.gray = (mx == mn);
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			side_s1 <= side_c;
			ax_s1   <= diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
			d_s1    <= mx - mn;
		end
	end

	// stage 2: scaled numerators and safe divisors
	logic [NUM_W-1:0] hnum_s2, snum_s2;
	logic [7:0]       hden_s2, sden_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			side_s2 <= side_s1;
			hnum_s2 <= (NUM_W'(ax_s1) * NUM_W'(60)) << FRAC_BITS;
			snum_s2 <= (NUM_W'(d_s1) * NUM_W'(100)) << FRAC_BITS;
			hden_s2 <= side_s1.gray ? 8'd1 : d_s1;
			sden_s2 <= side_s1.gray ? 8'd1 : side_s1.mx;
		end
	end

	// divider stages, side info travels in step
	logic [NUM_W-1:0] hq, sq;
	logic [7:0]       hrem;
	side_t            side_dv [DIV_STAGES];

	rhsv_div #(.NUM_W(NUM_W), .STEP(STEP)) u_hue_div (
		.clk (clk),
		.en  (rdy[2 +: DIV_STAGES]),
		.num (hnum_s2),
		.den (hden_s2),
		.quo (hq),
		.rem (hrem)
	);

	rhsv_div #(.NUM_W(NUM_W), .STEP(STEP)) u_sat_div (
		.clk (clk),
		.en  (rdy[2 +: DIV_STAGES]),
		.num (snum_s2),
		.den (sden_s2),
		.quo (sq),
		.rem ()
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (rdy[2]) side_dv[0] <= side_s2;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (rdy[2+k]) side_dv[k] <= side_dv[k-1];
			end
		end
	end

	// fix-up stage: sector offset, floor for negative differences
	side_t            side_f;
	logic [HUE_W-1:0] q15, base, hue_c;
	logic [HUE_W-1:0] hue_s3;
	logic [SAT_W-1:0] sat_s3;
	logic [VAL_W-1:0] bright_s3;

	assign side_f = side_dv[DIV_STAGES-1];
	assign q15    = hq[HUE_W-1:0];

	always_comb begin
		case (side_f.sector)
			SEC_RED:   base = side_f.neg ? H360 : '0;
			SEC_GREEN: base = H120;
			SEC_BLUE:  base = H240;
			default:   base = '0;
		endcase
		if (side_f.gray)
			hue_c = '0;
		else if (side_f.neg)
			hue_c = base - q15 - HUE_W'(|hrem);
		else
			hue_c = base + q15;
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_FIX]) begin
			hue_s3    <= hue_c;
			sat_s3    <= side_f.gray ? '0 : sq[SAT_W-1:0];
			bright_s3 <= side_f.mx;
		end
	end

	// window test and output register
	logic             hue_ok, pass_c;
	logic             pass_s4;
	logic [HUE_W-1:0] hue_s4;
	logic [SAT_W-1:0] sat_s4;
	logic [VAL_W-1:0] bright_s4;

	always_comb begin
		if (hue_min_q < hue_max_q)
			hue_ok = (hue_min_q <= hue_s3) && (hue_s3 <= hue_max_q);
		else
			hue_ok = (hue_min_q <= hue_s3) || (hue_s3 <= hue_max_q);
		pass_c = hue_ok && (sat_min_q <= sat_s3) && (sat_s3 <= sat_max_q) &&
			(val_min_q <= bright_s3) && (bright_s3 <= val_max_q);
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_OUT]) begin
			pass_s4   <= pass_c;
			hue_s4    <= hue_s3;
			sat_s4    <= sat_s3;
			bright_s4 <= bright_s3;
		end
	end

	assign result.valid      = vld_q[ST_OUT];
	assign result.pass       = pass_s4;
	assign result.hue        = hue_s4;
	assign result.saturation = sat_s4;
	assign result.brightness = bright_s4;

endmodule

// ===== hdl/rhsv_checker.sv =====
`include "rgb_to_hsv_color_threshold_defines.svh"

// Port-level checks for the color threshold block.
module rhsv_props (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_wr_en,
	input logic [rhsv_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rhsv_pkg::CFG_W-1:0]     cfg_data,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           out_pass,
	input logic [rhsv_pkg::HUE_W-1:0]     out_hue,
	input logic [rhsv_pkg::SAT_W-1:0]     out_saturation,
	input logic [rhsv_pkg::VAL_W-1:0]     out_brightness
);
	import rhsv_pkg::*;

	// shadow of the saturation and value windows
	logic [SAT_W-1:0] sat_min_q, sat_max_q;
	logic [VAL_W-1:0] val_min_q, val_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_min_q <= SAT_MIN_RST;
			sat_max_q <= SAT_MAX_RST;
			val_min_q <= VAL_MIN_RST;
			val_max_q <= VAL_MAX_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SAT_MIN: sat_min_q <= cfg_data[SAT_W-1:0];
				CFG_SAT_MAX: sat_max_q <= cfg_data[SAT_W-1:0];
				CFG_VAL_MIN: val_min_q <= cfg_data[VAL_W-1:0];
				CFG_VAL_MAX: val_max_q <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// pixels accepted but not yet delivered
	logic [7:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
		end
	end

	`RHSV_ASSERT(a_stall_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable({out_pass, out_hue, out_saturation, out_brightness}), "result changed while stalled")
	`RHSV_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid, "result valid after reset")
	`RHSV_ASSERT(a_no_phantom, clk, arst_n, out_valid |-> cnt_q != 8'd0, "result with no pixel in flight")
	`RHSV_ASSERT(a_pass_window, clk, arst_n, out_valid && out_pass |-> (out_brightness >= val_min_q && out_brightness <= val_max_q && out_saturation >= sat_min_q && out_saturation <= sat_max_q), "pass outside window")

endmodule

bind rgb_to_hsv_color_threshold rhsv_props u_rhsv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cfg_wr_en      (cfg_wr_en),
	.cfg_index      (cfg_index),
	.cfg_data       (cfg_data),
	.in_valid       (pixel.valid),
	.in_ready       (pixel.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_pass       (result.pass),
	.out_hue        (result.hue),
	.out_saturation (result.saturation),
	.out_brightness (result.brightness)
);

// ===== test/rhsv_checker.sv =====
`timescale 1ns / 1ps

// Watches the pixel, result and register ports, predicts each result and compares.
module rhsv_checker
	import rhsv_pkg::*;
#(
	parameter int FRAC_BITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rhsv_pix_if                  pixel,
	rhsv_res_if                  result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   pending,
	output int                   mismatches
);

	typedef struct packed {
		logic             pass;
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [VAL_W-1:0] brightness;
	} hsv_verdict_t;

	// local copy of the window registers
	logic [HUE_W-1:0] hue_lo, hue_hi;
	logic [SAT_W-1:0] sat_lo, sat_hi;
	logic [VAL_W-1:0] val_lo, val_hi;

	hsv_verdict_t verdict_q[$];
	hsv_verdict_t want;
	int           err_total;

	// quotient rounded toward minus infinity, den > 0
	function automatic longint floor_quot(longint num, longint den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic hsv_verdict_t classify_pixel(logic [VAL_W-1:0] r, logic [VAL_W-1:0] g,
			logic [VAL_W-1:0] b);
		longint       unit;
		longint       rr, gg, bb, mx, mn, d, h, s;
		logic         hue_ok;
		hsv_verdict_t v;
		unit = longint'(1) << FRAC_BITS;
		rr = longint'(r);
		gg = longint'(g);
		bb = longint'(b);
		mx = (rr > gg) ? ((rr > bb) ? rr : bb) : ((gg > bb) ? gg : bb);
		mn = (rr < gg) ? ((rr < bb) ? rr : bb) : ((gg < bb) ? gg : bb);
		d = mx - mn;
		h = 0;
		s = 0;
		// gray pixels keep hue and saturation at zero
		if (d != 0) begin
			// ties for the maximum go to red, then green
			if (mx == rr) begin
				h = floor_quot(60 * unit * (gg - bb), d);
				if (h < 0)
					h += 360 * unit;
			end else if (mx == gg) begin
				h = floor_quot(60 * unit * (bb - rr), d) + 120 * unit;
			end else begin
				h = floor_quot(60 * unit * (rr - gg), d) + 240 * unit;
			end
			s = (100 * unit * d) / mx;
		end
		v.hue        = h[HUE_W-1:0];
		v.saturation = s[SAT_W-1:0];
		v.brightness = mx[VAL_W-1:0];
		// hue window wraps through zero unless min is below max
		if (hue_lo < hue_hi)
			hue_ok = (v.hue >= hue_lo) && (v.hue <= hue_hi);
		else
			hue_ok = (v.hue >= hue_lo) || (v.hue <= hue_hi);
		v.pass = hue_ok && (v.saturation >= sat_lo) && (v.saturation <= sat_hi) &&
			(v.brightness >= val_lo) && (v.brightness <= val_hi);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_lo = HUE_MIN_RST;
			hue_hi = HUE_MAX_RST;
			sat_lo = SAT_MIN_RST;
			sat_hi = SAT_MAX_RST;
			val_lo = VAL_MIN_RST;
			val_hi = VAL_MAX_RST;
			verdict_q.delete();
			err_total = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			// register writes, masked to register width
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_HUE_MIN: hue_lo = cfg_data[HUE_W-1:0];
					CFG_HUE_MAX: hue_hi = cfg_data[HUE_W-1:0];
					CFG_SAT_MIN: sat_lo = cfg_data[SAT_W-1:0];
					CFG_SAT_MAX: sat_hi = cfg_data[SAT_W-1:0];
					CFG_VAL_MIN: val_lo = cfg_data[VAL_W-1:0];
					CFG_VAL_MAX: val_hi = cfg_data[VAL_W-1:0];
					default: ;
				endcase
			end

			// accepted pixel request: queue its verdict
			if (pixel.valid && pixel.ready)
				verdict_q.push_back(classify_pixel(pixel.red, pixel.green, pixel.blue));

			// accepted result: compare with oldest verdict
			if (result.valid && result.ready) begin
				if (verdict_q.size() == 0) begin
					$error("result with no pixel outstanding: pass %0d hue %0d sat %0d val %0d",
						result.pass, result.hue, result.saturation, result.brightness);
					err_total++;
				end else begin
					want = verdict_q.pop_front();
					if (result.pass !== want.pass) begin
						$error("pass: expected %0d, got %0d", want.pass, result.pass);
						err_total++;
					end
					if (result.hue !== want.hue) begin
						$error("hue: expected %0d, got %0d", want.hue, result.hue);
						err_total++;
					end
					if (result.saturation !== want.saturation) begin
						$error("saturation: expected %0d, got %0d", want.saturation,
							result.saturation);
						err_total++;
					end
					if (result.brightness !== want.brightness) begin
						$error("brightness: expected %0d, got %0d", want.brightness,
							result.brightness);
						err_total++;
					end
				end
			end

			pending <= verdict_q.size();
			mismatches <= err_total;
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import rhsv_pkg::*;

	localparam int FRAC_BITS   = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 20;
	localparam int CHUNK_ITEMS = 215;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   pending;
	int                   mismatches;
	int                   cycle_count = 0;
	bit                   tx_steady = 1'b0;
	bit                   rx_steady = 1'b0;

	rhsv_pix_if pix_ch();
	rhsv_res_if res_ch();

	rgb_to_hsv_color_threshold #(
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pix_ch),
		.result(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rhsv_checker #(
		.FRAC_BITS(FRAC_BITS)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pix_ch),
		.result(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.mismatches(mismatches)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls before taking each result
	initial begin : rx_side
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// one pixel request, with a random gap in front
	task automatic send_pixel(input logic [VAL_W-1:0] r, input logic [VAL_W-1:0] g,
			input logic [VAL_W-1:0] b);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.red   <= r;
		pix_ch.green <= g;
		pix_ch.blue  <= b;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic program_window(input logic [CFG_W-1:0] h_lo, input logic [CFG_W-1:0] h_hi,
			input logic [CFG_W-1:0] s_lo, input logic [CFG_W-1:0] s_hi,
			input logic [CFG_W-1:0] v_lo, input logic [CFG_W-1:0] v_hi);
		drain();
		write_reg(CFG_HUE_MIN, h_lo);
		write_reg(CFG_HUE_MAX, h_hi);
		write_reg(CFG_SAT_MIN, s_lo);
		write_reg(CFG_SAT_MAX, s_hi);
		write_reg(CFG_VAL_MIN, v_lo);
		write_reg(CFG_VAL_MAX, v_hi);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_window();
		int h_lo, h_hi, s_lo, s_hi, v_lo, v_hi;
		h_lo = $urandom_range(0, 23039);
		h_hi = $urandom_range(0, 23039);
		s_lo = $urandom_range(0, 3200);
		s_hi = $urandom_range(s_lo, 6400);
		v_lo = $urandom_range(0, 128);
		v_hi = $urandom_range(v_lo, 255);
		program_window(CFG_W'(h_lo), CFG_W'(h_hi), CFG_W'(s_lo), CFG_W'(s_hi),
			CFG_W'(v_lo), CFG_W'(v_hi));
	endtask

	// random pixels: mostly uniform, with gray, tied-maximum and low-contrast ones mixed in
	task automatic random_pixels(input int count);
		logic [VAL_W-1:0] ch[3];
		int               kind, top_v, low_v, base, odd;
		for (int i = 0; i < count; i++) begin
			if (i % 54 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					ch[0] = VAL_W'($urandom_range(0, 255));
					ch[1] = ch[0];
					ch[2] = ch[0];
				end
				1: begin
					top_v = $urandom_range(1, 255);
					low_v = $urandom_range(0, top_v - 1);
					odd = $urandom_range(0, 2);
					for (int k = 0; k < 3; k++)
						ch[k] = (k == odd) ? VAL_W'(low_v) : VAL_W'(top_v);
				end
				2: begin
					base = $urandom_range(0, 253);
					for (int k = 0; k < 3; k++)
						ch[k] = VAL_W'(base + $urandom_range(0, 2));
				end
				default: begin
					for (int k = 0; k < 3; k++)
						ch[k] = VAL_W'($urandom_range(0, 255));
				end
			endcase
			send_pixel(ch[0], ch[1], ch[2]);
		end
	endtask

	initial begin
		pix_ch.valid <= 1'b0;
		pix_ch.red   <= '0;
		pix_ch.green <= '0;
		pix_ch.blue  <= '0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= CFG_HUE_MIN;
		cfg_data     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pixels under the open reset window
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);   // red and green tie
		send_pixel(8'd0, 8'd255, 8'd255);   // green and blue tie
		send_pixel(8'd255, 8'd0, 8'd255);   // red and blue tie
		send_pixel(8'd255, 8'd0, 8'd1);     // red max, hue just below 360
		send_pixel(8'd255, 8'd1, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd254); // smallest nonzero saturation
		send_pixel(8'd1, 8'd0, 8'd1);
		send_pixel(8'd200, 8'd100, 8'd50);
		send_pixel(8'd50, 8'd100, 8'd200);
		send_pixel(8'd100, 8'd200, 8'd50);
		random_pixels(CHUNK_ITEMS);

		// all bounds at zero: equal hue bounds open the whole circle, only black passes
		program_window(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
		send_pixel(8'd0, 8'd0, 8'd0);
		random_pixels(CHUNK_ITEMS);

		// all bounds at the top of their range
		program_window(15'd23039, 15'd23039, 15'd6400, 15'd6400, 15'd255, 15'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		random_pixels(CHUNK_ITEMS);

		// hue window wrapping through zero
		program_window(15'd20000, 15'd3000, 15'd1000, 15'd6400, 15'd30, 15'd255);
		random_pixels(CHUNK_ITEMS);

		// every data bit set; hue and saturation bounds beyond their range
		program_window(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
		random_pixels(CHUNK_ITEMS / 2);
		program_window(15'd0, 15'd30000, 15'd0, 15'd8000, 15'd0, 15'd255);
		random_pixels(CHUNK_ITEMS / 2);

		// random windows
		for (int p = 0; p < 4; p++) begin
			random_window();
			random_pixels(CHUNK_ITEMS);
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rhsv_pkg.sv
hdl/rhsv_ifs.sv
hdl/rhsv_div.sv
hdl/rgb_to_hsv_color_threshold.sv
hdl/rhsv_checker.sv
test/rhsv_checker.sv
test/tb_top.sv
